// ===== rtl/core/pngcpe_pkg.sv =====
// Package for the PNG chunk prefix extractor.
// Phase codes, chunk constants, result FIFO sizing and the push bundle.
// No dependencies.
`default_nettype none

package pngcpe_pkg;

    // Parser phases
    localparam logic [2:0] PH_SIG  = 3'd0;
    localparam logic [2:0] PH_HEAD = 3'd1;
    localparam logic [2:0] PH_DATA = 3'd2;
    localparam logic [2:0] PH_CRC  = 3'd3;
    localparam logic [2:0] PH_STOP = 3'd4;

    // Byte counts of the fixed parts of the stream
    localparam logic [31:0] SigLen  = 32'd8;
    localparam logic [31:0] HeadLen = 32'd8;
    localparam logic [31:0] CrcLen  = 32'd4;
    localparam int          BurstN  = 8;

    // Chunk type characters
    localparam logic [7:0] ChI = 8'h49;
    localparam logic [7:0] ChD = 8'h44;
    localparam logic [7:0] ChA = 8'h41;
    localparam logic [7:0] ChT = 8'h54;
    localparam logic [7:0] ChE = 8'h45;
    localparam logic [7:0] ChN = 8'h4E;

    // Result FIFO: holds one header burst plus the bytes queued behind it
    localparam int          FifoDepth = 16;
    localparam int          FifoAw    = 4;
    localparam int          CntW      = 5;
    localparam logic [CntW-1:0] AcceptMax = 5'd8;
    localparam logic [CntW-1:0] DepthCnt  = 5'd16;

    // Results produced by one accepted item
    typedef struct packed {
        logic [3:0]            num;
        logic [BurstN-1:0][7:0] bytes;
    } push_t;

endpackage

`default_nettype wire

// ===== rtl/core/pngcpe_parser.sv =====
// Chunk parser: phase, byte counter, held header and IEND flag.
// Turns each accepted item into zero, one or eight result bytes.
// Depends on pngcpe_pkg.
`default_nettype none

module pngcpe_parser
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic [7:0]        in_byte,
    output pngcpe_pkg::push_t      push
);

    logic [2:0]  phase_reg, phase_next;
    logic [31:0] left_reg, left_next;
    logic        iend_reg, iend_next;
    logic [7:0]  store_reg [0:7];

    logic [2:0]  hidx;
    logic        hdr_done;
    logic        is_idat;
    logic        is_iend;
    logic [31:0] chunk_len;

    // Header byte position and type decode (last type byte is the current item)
    assign hidx      = 3'(4'd8 - left_reg[3:0]);
    assign hdr_done  = (left_reg == 32'd1);
    assign is_idat   = (store_reg[4] == pngcpe_pkg::ChI) && (store_reg[5] == pngcpe_pkg::ChD)
                    && (store_reg[6] == pngcpe_pkg::ChA) && (in_byte == pngcpe_pkg::ChT);
    assign is_iend   = (store_reg[4] == pngcpe_pkg::ChI) && (store_reg[5] == pngcpe_pkg::ChE)
                    && (store_reg[6] == pngcpe_pkg::ChN) && (in_byte == pngcpe_pkg::ChD);
    assign chunk_len = {store_reg[0], store_reg[1], store_reg[2], store_reg[3]};

    // Next state and results for one item
    always_comb
    begin
        phase_next = phase_reg;
        left_next  = left_reg;
        iend_next  = iend_reg;
        push.num   = 4'd0;
        for (int k = 0; k < pngcpe_pkg::BurstN - 1; k++)
        begin
            push.bytes[k] = store_reg[k];
        end
        push.bytes[pngcpe_pkg::BurstN-1] = in_byte;

        case (phase_reg)
            pngcpe_pkg::PH_SIG:
            begin
                push.num      = 4'd1;
                push.bytes[0] = in_byte;
                if (left_reg > 32'd1)
                begin
                    left_next = left_reg - 32'd1;
                end
                else
                begin
                    phase_next = pngcpe_pkg::PH_HEAD;
                    left_next  = pngcpe_pkg::HeadLen;
                end
            end
            pngcpe_pkg::PH_HEAD:
            begin
                left_next = left_reg - 32'd1;
                if (hdr_done)
                begin
                    if (is_idat)
                    begin
                        phase_next = pngcpe_pkg::PH_STOP;
                    end
                    else
                    begin
                        push.num  = 4'd8;
                        iend_next = is_iend;
                        if (chunk_len == 32'd0)
                        begin
                            phase_next = pngcpe_pkg::PH_CRC;
                            left_next  = pngcpe_pkg::CrcLen;
                        end
                        else
                        begin
                            phase_next = pngcpe_pkg::PH_DATA;
                            left_next  = chunk_len;
                        end
                    end
                end
            end
            pngcpe_pkg::PH_DATA:
            begin
                push.num      = 4'd1;
                push.bytes[0] = in_byte;
                if (left_reg > 32'd1)
                begin
                    left_next = left_reg - 32'd1;
                end
                else
                begin
                    phase_next = pngcpe_pkg::PH_CRC;
                    left_next  = pngcpe_pkg::CrcLen;
                end
            end
            pngcpe_pkg::PH_CRC:
            begin
                push.num      = 4'd1;
                push.bytes[0] = in_byte;
                if (left_reg > 32'd1)
                begin
                    left_next = left_reg - 32'd1;
                end
                else if (iend_reg)
                begin
                    phase_next = pngcpe_pkg::PH_STOP;
                    left_next  = 32'd0;
                end
                else
                begin
                    phase_next = pngcpe_pkg::PH_HEAD;
                    left_next  = pngcpe_pkg::HeadLen;
                end
            end
            default:
            begin
                push.num = 4'd0;
            end
        endcase

        if (!accept)
        begin
            push.num = 4'd0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= pngcpe_pkg::PH_SIG;
            left_reg  <= pngcpe_pkg::SigLen;
            iend_reg  <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
            iend_reg  <= iend_next;
        end
    end

    // Held length and type bytes
    always_ff @(posedge clk)
    begin
        if (accept && (phase_reg == pngcpe_pkg::PH_HEAD))
        begin
            store_reg[hidx] <= in_byte;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/pngcpe_fifo.sv =====
// Result FIFO: takes up to eight bytes per cycle, gives one per cycle on pop.
// The head entry drives the output ports directly.
// Depends on pngcpe_pkg.
`default_nettype none

module pngcpe_fifo
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire pngcpe_pkg::push_t                 push,
    input  wire logic                              pop,
    output logic [7:0]                             head_byte,
    output logic                                   head_last,
    output logic [pngcpe_pkg::CntW-1:0]            count
);

    logic [8:0]                      mem_reg [0:pngcpe_pkg::FifoDepth-1];
    logic [pngcpe_pkg::FifoAw-1:0]   wr_reg;
    logic [pngcpe_pkg::FifoAw-1:0]   rd_reg;
    logic [pngcpe_pkg::CntW-1:0]     cnt_reg, cnt_next;

    assign head_byte = mem_reg[rd_reg][7:0];
    assign head_last = mem_reg[rd_reg][8];
    assign count     = cnt_reg;
    assign cnt_next  = cnt_reg + pngcpe_pkg::CntW'(push.num)
                     - pngcpe_pkg::CntW'(pop);

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_reg + pngcpe_pkg::FifoAw'(push.num);
            rd_reg  <= rd_reg + pngcpe_pkg::FifoAw'(pop);
            cnt_reg <= cnt_next;
        end
    end

    // Multi-entry write; last flag on the final byte of the item
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < pngcpe_pkg::BurstN; k++)
        begin
            if (4'(k) < push.num)
            begin
                mem_reg[wr_reg + pngcpe_pkg::FifoAw'(k)] <=
                    {(4'(k) == push.num - 4'd1), push.bytes[k]};
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/png_chunk_prefix_extractor.sv =====
// PNG chunk prefix extractor, top level.
// Instantiates pngcpe_parser and pngcpe_fifo; depends on pngcpe_pkg.
//
// Takes a PNG stream one byte per cycle while in_stall is low and returns
// the part before the first IDAT chunk: signature, then per chunk its
// length, type, data and CRC bytes. An input item is taken every cycle
// while fewer than nine results are queued. Signature, data and CRC
// items give one result each with last_in_run set; the eighth header
// item of a non-IDAT chunk gives the whole 8-byte header as a burst,
// last_in_run on its final byte. Results leave one per cycle while
// out_stall is low from a 16-entry FIFO, whose head drives the output
// ports, so input and output run independently. After an IDAT header or
// the CRC of IEND the block drops all further input until reset. With the
// FIFO empty, an item's first result shows in the cycle after its accept.
`default_nettype none

module png_chunk_prefix_extractor
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] in_byte,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      out_byte,
    output logic            last_in_run
);

    pngcpe_pkg::push_t                 push;
    logic                              accept;
    logic                              pop;
    logic [pngcpe_pkg::CntW-1:0]       count;

    // Room for a full burst decides whether an item is taken
    assign in_stall  = (count > pngcpe_pkg::AcceptMax);
    assign accept    = in_valid && !in_stall;
    assign out_valid = (count != '0);
    assign pop       = out_valid && !out_stall;

    pngcpe_parser u_parser
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_byte (in_byte),
        .push    (push)
    );

    pngcpe_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (pop),
        .head_byte (out_byte),
        .head_last (last_in_run),
        .count     (count)
    );

    // FIFO never overfills
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count <= pngcpe_pkg::DepthCnt)
        else $error("result FIFO overflow");

    // An item yields nothing, one byte or a full header burst
    a_push_size: assert property (@(posedge clk) disable iff (!rst_n)
        (push.num == 4'd0) || (push.num == 4'd1) || (push.num == 4'd8))
        else $error("bad result count per item");

    // Nothing is queued without an accepted item
    a_push_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (push.num != 4'd0) |-> accept)
        else $error("results without an accepted item");

endmodule

`default_nettype wire
